[rtl/core/assert_macros.svh]
// Assertion helpers, clocked on a rising edge and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent at the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/arpc_pkg.sv]
package arpc_pkg;

    localparam int DEFAULT_ENTRIES = 256;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int STAMP_W = 32;
    localparam int OPER_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    localparam logic [OPER_W-1:0] OPER_REQUEST = 16'd1;
    localparam logic [OPER_W-1:0] OPER_REPLY   = 16'd2;

    localparam logic ACT_PACKET  = 1'b0;
    localparam logic ACT_RESOLVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

[rtl/core/arpc_ram.sv]
module arpc_ram #(
    parameter int DEPTH  = arpc_pkg::DEFAULT_ENTRIES,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  arpc_pkg::t_entry    i_wdata,
    input  logic                i_re,
    input  logic [ADDR_W-1:0]   i_raddr,
    output arpc_pkg::t_entry    o_rdata
);
    import arpc_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/arp_cache_engine.sv]
// ARP cache engine. Every item is answered by exactly one result, shown for
// one cycle with o_valid; there is no backpressure. An item walks the whole
// table through the entry memory (one write port, one read port), one read
// per cycle, and then passes through S_DRAIN and S_FINISH to its result;
// packet items with an opcode other than request or reply skip the walk and
// go straight to S_FINISH. busy drops in the cycle the result is shown, so
// the next item may start then. After reset the memory is cleared one entry
// per cycle with busy high; configuration writes are taken at any time.
`include "assert_macros.svh"

module arp_cache_engine #(
    parameter int ENTRIES = arpc_pkg::DEFAULT_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_action,
    input  logic [arpc_pkg::MAC_W-1:0]          i_frame_src_mac,
    input  logic [arpc_pkg::OPER_W-1:0]         i_arp_oper,
    input  logic [arpc_pkg::MAC_W-1:0]          i_sender_mac,
    input  logic [arpc_pkg::IP_W-1:0]           i_sender_ip,
    input  logic [arpc_pkg::IP_W-1:0]           i_target_ip,
    input  logic [arpc_pkg::STAMP_W-1:0]        i_now,
    output logic                                o_valid,
    output logic                                o_send_reply,
    output logic [arpc_pkg::MAC_W-1:0]          o_reply_dest_mac,
    output logic [arpc_pkg::MAC_W-1:0]          o_reply_target_mac,
    output logic [arpc_pkg::IP_W-1:0]           o_reply_target_ip,
    output logic                                o_found,
    output logic [arpc_pkg::MAC_W-1:0]          o_resolved_mac
);
    import arpc_pkg::*;

    localparam int ADDR_W = $clog2(ENTRIES);
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_rd_idx;

    logic [IP_W-1:0]     r_own_ip;
    logic [MAC_W-1:0]    r_own_mac;

    logic                r_action;
    logic [MAC_W-1:0]    r_frame_src_mac;
    logic [OPER_W-1:0]   r_arp_oper;
    logic [MAC_W-1:0]    r_sender_mac;
    logic [IP_W-1:0]     r_sender_ip;
    logic [IP_W-1:0]     r_target_ip;
    logic [STAMP_W-1:0]  r_now;

    logic                r_hit;
    logic [ADDR_W-1:0]   r_hit_idx;
    logic [MAC_W-1:0]    r_hit_mac;
    logic                r_free;
    logic [ADDR_W-1:0]   r_free_idx;
    logic                r_old_vld;
    logic [ADDR_W-1:0]   r_old_idx;
    logic [STAMP_W-1:0]  r_old_stamp;

    logic                accept;
    logic                learn;
    logic                reply;
    logic [IP_W-1:0]     key;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    t_entry              ram_wdata;
    logic                ram_re;
    t_entry              ram_rdata;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign learn  = (r_action == ACT_PACKET)
                 && ((r_arp_oper == OPER_REQUEST) || (r_arp_oper == OPER_REPLY));
    assign reply  = (r_action == ACT_PACKET) && (r_arp_oper == OPER_REQUEST)
                 && (r_target_ip == r_own_ip);
    assign key    = (r_action == ACT_RESOLVE) ? r_target_ip : r_sender_ip;
    assign ram_re = (r_state == S_SCAN);

    // clear entries in S_CLEAR; on a learning finish, refresh a hit, else highest free slot, else oldest entry
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_state == S_FINISH && learn) begin
            ram_we          = 1'b1;
            ram_wdata.valid = 1'b1;
            ram_wdata.ip    = r_sender_ip;
            ram_wdata.mac   = r_sender_mac;
            ram_wdata.stamp = r_now;
            priority if (r_hit) begin
                ram_waddr = r_hit_idx;
            end else if (r_free) begin
                ram_waddr = r_free_idx;
            end else begin
                ram_waddr = r_old_idx;
            end
        end
    end

    arpc_ram #(
        .DEPTH  (ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_own_mac <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OWN_IP:  r_own_ip  <= i_cfg_data[IP_W-1:0];
                REG_OWN_MAC: r_own_mac <= i_cfg_data[MAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action        <= i_action;
            r_frame_src_mac <= i_frame_src_mac;
            r_arp_oper      <= i_arp_oper;
            r_sender_mac    <= i_sender_mac;
            r_sender_ip     <= i_sender_ip;
            r_target_ip     <= i_target_ip;
            r_now           <= i_now;
        end
    end

    // scan accumulators, fed one entry per cycle from the memory
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (accept) begin
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_old_vld <= 1'b0;
        end else if (r_rd_vld) begin
            if (ram_rdata.valid && ram_rdata.ip == key && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
                r_hit_mac <= ram_rdata.mac;
            end
            if (!ram_rdata.valid) begin
                r_free     <= 1'b1;
                r_free_idx <= r_rd_idx;
            end else if (!r_old_vld || ram_rdata.stamp < r_old_stamp) begin
                r_old_vld   <= 1'b1;
                r_old_idx   <= r_rd_idx;
                r_old_stamp <= ram_rdata.stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN);
            o_valid  <= (r_state == S_FINISH);
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= (r_addr == LAST) ? '0 : r_addr + 1'b1;
                    if (r_addr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_addr <= '0;
                        if (i_action == ACT_PACKET && i_arp_oper != OPER_REQUEST
                                && i_arp_oper != OPER_REPLY) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    o_send_reply       <= reply;
                    o_reply_dest_mac   <= reply ? r_frame_src_mac : '0;
                    o_reply_target_mac <= reply ? r_sender_mac : '0;
                    o_reply_target_ip  <= reply ? r_sender_ip : '0;
                    o_found            <= (r_action == ACT_RESOLVE) && r_hit;
                    o_resolved_mac     <= ((r_action == ACT_RESOLVE) && r_hit)
                                          ? r_hit_mac : '0;
                    r_state            <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_strobe_after_finish, i_clk, i_rst_n, r_state == S_FINISH, o_valid, "result strobe missing after finish")
    `ASSERT_IMPLIES(a_write_phase, i_clk, i_rst_n, ram_we, r_state == S_CLEAR || r_state == S_FINISH, "table written during scan")
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state == S_SCAN || r_state == S_FINISH, "accepted item did not start")
    `ASSERT_IMPLIES(a_found_xor_reply, i_clk, i_rst_n, o_valid, !(o_found && o_send_reply), "resolve and reply in one result")

endmodule
